// ----- design/ddsc_pkg.sv -----
`timescale 1ns / 1ps
package ddsc_pkg;

    localparam int MAX_NODES_DEF       = 1024;
    localparam int MAX_WORD_DIGITS_DEF = 9;
    localparam int DIGIT_BASE_DEF      = 10;

    localparam int          WAYS_W   = 30;
    localparam logic [30:0] WAYS_MOD = 31'd1000000007;

    // operation codes
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_WORD  = 2'd1;
    localparam logic [1:0] OP_MSG   = 2'd2;

    typedef struct packed {
        logic [1:0] op;
        logic [3:0] digit;
        logic       last;
    } t_cmd;

    typedef struct packed {
        logic [WAYS_W-1:0] ways;
        logic              overflow;
    } t_result;

    // both operands below the modulus, so one conditional subtract suffices
    function automatic logic [WAYS_W-1:0] add_mod(input logic [WAYS_W-1:0] a,
                                                 input logic [WAYS_W-1:0] b);
        logic [30:0] s;
        logic [30:0] t;
        s = {1'b0, a} + {1'b0, b};
        t = (s >= WAYS_MOD) ? (s - WAYS_MOD) : s;
        return t[WAYS_W-1:0];
    endfunction

endpackage

// ----- design/ddsc_trie_mem.sv -----
`timescale 1ns / 1ps
module ddsc_trie_mem #(
    parameter int MAX_NODES  = ddsc_pkg::MAX_NODES_DEF,
    parameter int DIGIT_BASE = ddsc_pkg::DIGIT_BASE_DEF
) (
    input  logic                                          i_clk,
    input  logic                                          i_child_rd,
    input  logic [$clog2(MAX_NODES*DIGIT_BASE)-1:0]       i_child_raddr,
    input  logic                                          i_child_we,
    input  logic [$clog2(MAX_NODES*DIGIT_BASE)-1:0]       i_child_waddr,
    input  logic [$clog2(MAX_NODES)-1:0]                  i_child_wdata,
    output logic [$clog2(MAX_NODES)-1:0]                  o_child_q,
    input  logic                                          i_mark_rd,
    input  logic [$clog2(MAX_NODES)-1:0]                  i_mark_raddr,
    input  logic                                          i_mark_we,
    input  logic [$clog2(MAX_NODES)-1:0]                  i_mark_waddr,
    input  logic                                          i_mark_wdata,
    output logic                                          o_mark_q
);
    import ddsc_pkg::*;

    localparam int NW    = $clog2(MAX_NODES);
    localparam int DEPTH = MAX_NODES * DIGIT_BASE;

    // child index per node and digit, zero means no edge
    logic [NW-1:0] r_child_mem [DEPTH];
    // word end flag per node
    logic          r_mark_mem  [MAX_NODES];

    always_ff @(posedge i_clk) begin
        if (i_child_we) begin
            r_child_mem[i_child_waddr] <= i_child_wdata;
        end
        if (i_child_rd) begin
            o_child_q <= r_child_mem[i_child_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_mark_we) begin
            r_mark_mem[i_mark_waddr] <= i_mark_wdata;
        end
        if (i_mark_rd) begin
            o_mark_q <= r_mark_mem[i_mark_raddr];
        end
    end

endmodule

// ----- design/digit_dictionary_segmentation_count.sv -----
`timescale 1ns / 1ps
// channel   | direction | handshake              | payload
// ----------+-----------+------------------------+--------------------------
// command   | in        | start high, busy low   | i_cmd (op, digit, last)
// result    | out       | o_done, one cycle      | o_result (ways, overflow)
//
// word digit: a child table read and a finish step, plus a row sweep when a trie node is
//   allocated (its child row is swept to zero through the table write port)
// message digit: each cursor slot in turn (idle slots skipped, live cursors
//   stepped), then the root step and the finish; the order is set by the
//   single read port of the child table and the chained mark lookup
// new case: the root row is swept to zero; after reset the same root row sweep
//   runs with busy high
// the result strobe is not back-pressured: it shows for one cycle only
module digit_dictionary_segmentation_count #(
    parameter int MAX_NODES       = ddsc_pkg::MAX_NODES_DEF,
    parameter int MAX_WORD_DIGITS = ddsc_pkg::MAX_WORD_DIGITS_DEF,
    parameter int DIGIT_BASE      = ddsc_pkg::DIGIT_BASE_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  ddsc_pkg::t_cmd    i_cmd,
    output logic              o_done,
    output ddsc_pkg::t_result o_result
);
    import ddsc_pkg::*;

    localparam int NW = $clog2(MAX_NODES);
    localparam int AW = $clog2(MAX_NODES * DIGIT_BASE);
    localparam int DW = (DIGIT_BASE > 2) ? $clog2(DIGIT_BASE) : 1;
    localparam int IW = $clog2(MAX_WORD_DIGITS + 1);
    localparam int SW = (MAX_WORD_DIGITS > 1) ? $clog2(MAX_WORD_DIGITS) : 1;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_CLR  = 4'd1;
    localparam logic [3:0] ST_WRD  = 4'd2;
    localparam logic [3:0] ST_WDAT = 4'd3;
    localparam logic [3:0] ST_WFIN = 4'd4;
    localparam logic [3:0] ST_MREQ = 4'd5;
    localparam logic [3:0] ST_MCHD = 4'd6;
    localparam logic [3:0] ST_MMRK = 4'd7;
    localparam logic [3:0] ST_MEND = 4'd8;

    logic [3:0]        r_state, n_state;
    t_cmd              r_cmd;
    // clear sweep over one child row
    logic [NW-1:0]     r_clr_node;
    logic [DW-1:0]     r_clr_cnt;
    logic              r_clr_to_fin;
    // insert side
    logic [NW:0]       r_nodes_used;
    logic [NW-1:0]     r_ins_cur;
    logic [IW-1:0]     r_ins_depth;
    logic              r_ins_drop;
    logic              r_ovf;
    logic [AW-1:0]     r_addr;
    // open cursor slots
    logic [NW-1:0]     r_slot_node  [MAX_WORD_DIGITS];
    logic              r_slot_alive [MAX_WORD_DIGITS];
    logic [WAYS_W-1:0] r_slot_ways  [MAX_WORD_DIGITS];
    logic [WAYS_W-1:0] r_prefix;
    logic [WAYS_W-1:0] r_acc;
    logic [WAYS_W-1:0] r_add_ways;
    logic [IW-1:0]     r_idx;
    // result register
    logic              r_done;
    t_result           r_res;

    // memory side
    logic              child_rd, child_we, mark_rd, mark_we, mark_wdata;
    logic              mark_q;
    logic [AW-1:0]     child_raddr, child_waddr;
    logic [NW-1:0]     child_wdata, child_q, mark_raddr, mark_waddr;

    logic              accept, dig_ok, is_root, free_found;
    logic [SW-1:0]     slot, free_slot;
    logic [WAYS_W-1:0] acc_new;

    function automatic logic [AW-1:0] row_addr(input logic [NW-1:0] node,
                                               input logic [3:0]    dig);
        return AW'(node) * AW'(DIGIT_BASE) + AW'(dig);
    endfunction

    assign accept  = start && !busy;
    assign dig_ok  = ({1'b0, r_cmd.digit} < 5'(DIGIT_BASE));
    assign is_root = (r_idx == IW'(MAX_WORD_DIGITS));
    assign slot    = r_idx[SW-1:0];
    assign acc_new = add_mod(r_acc, r_add_ways);

    // first free cursor slot for a new start
    always_comb begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int s = 0; s < MAX_WORD_DIGITS; s++) begin
            if (!free_found && !r_slot_alive[s]) begin
                free_found = 1'b1;
                free_slot  = SW'(s);
            end
        end
    end

    // memory requests per state
    always_comb begin
        child_rd    = 1'b0;
        child_raddr = r_addr;
        child_we    = 1'b0;
        child_waddr = r_addr;
        child_wdata = r_nodes_used[NW-1:0];
        mark_rd     = 1'b0;
        mark_raddr  = child_q;
        mark_we     = 1'b0;
        mark_waddr  = r_ins_cur;
        mark_wdata  = 1'b1;
        case (r_state)
            ST_CLR: begin
                child_we    = 1'b1;
                child_waddr = row_addr(r_clr_node, 4'(r_clr_cnt));
                child_wdata = '0;
                mark_we     = (r_clr_cnt == '0);
                mark_waddr  = r_clr_node;
                mark_wdata  = 1'b0;
            end
            ST_WRD: begin
                child_rd    = 1'b1;
                child_raddr = row_addr(r_ins_cur, r_cmd.digit);
            end
            ST_WDAT: begin
                child_we = (child_q == '0) && (r_nodes_used < (NW+1)'(MAX_NODES));
            end
            ST_WFIN: begin
                mark_we = r_cmd.last && !r_ins_drop;
            end
            ST_MREQ: begin
                child_rd    = 1'b1;
                child_raddr = is_root ? row_addr('0, r_cmd.digit)
                                      : row_addr(r_slot_node[slot], r_cmd.digit);
            end
            ST_MCHD: begin
                mark_rd = (child_q != '0);
            end
            default: begin
            end
        endcase
    end

    ddsc_trie_mem #(
        .MAX_NODES  (MAX_NODES),
        .DIGIT_BASE (DIGIT_BASE)
    ) u_mem (
        .i_clk         (i_clk),
        .i_child_rd    (child_rd),
        .i_child_raddr (child_raddr),
        .i_child_we    (child_we),
        .i_child_waddr (child_waddr),
        .i_child_wdata (child_wdata),
        .o_child_q     (child_q),
        .i_mark_rd     (mark_rd),
        .i_mark_raddr  (mark_raddr),
        .i_mark_we     (mark_we),
        .i_mark_waddr  (mark_waddr),
        .i_mark_wdata  (mark_wdata),
        .o_mark_q      (mark_q)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_cmd.op)
                        OP_CLEAR: n_state = ST_CLR;
                        OP_WORD:  n_state = ST_WRD;
                        OP_MSG:   n_state = ST_MREQ;
                        default:  n_state = ST_IDLE;
                    endcase
                end
            end
            ST_CLR: begin
                if (r_clr_cnt == DW'(DIGIT_BASE - 1)) begin
                    n_state = r_clr_to_fin ? ST_WFIN : ST_IDLE;
                end
            end
            ST_WRD: begin
                if (r_ins_drop || !dig_ok || r_ins_depth >= IW'(MAX_WORD_DIGITS)) begin
                    n_state = ST_WFIN;
                end else begin
                    n_state = ST_WDAT;
                end
            end
            ST_WDAT: n_state = child_we ? ST_CLR : ST_WFIN;
            ST_WFIN: n_state = ST_IDLE;
            ST_MREQ: begin
                if (is_root) begin
                    n_state = (dig_ok && r_cmd.digit != 4'd0) ? ST_MCHD : ST_MEND;
                end else if (r_slot_alive[slot] && dig_ok) begin
                    n_state = ST_MCHD;
                end
            end
            ST_MCHD: begin
                if (child_q != '0) begin
                    n_state = ST_MMRK;
                end else begin
                    n_state = is_root ? ST_MEND : ST_MREQ;
                end
            end
            ST_MMRK: n_state = is_root ? ST_MEND : ST_MREQ;
            ST_MEND: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLR;
            r_clr_node   <= '0;
            r_clr_cnt    <= '0;
            r_clr_to_fin <= 1'b0;
            r_nodes_used <= (NW+1)'(1);
            r_ins_cur    <= '0;
            r_ins_depth  <= '0;
            r_ins_drop   <= 1'b0;
            r_ovf        <= 1'b0;
            r_prefix     <= WAYS_W'(1);
            r_done       <= 1'b0;
            for (int s = 0; s < MAX_WORD_DIGITS; s++) begin
                r_slot_alive[s] <= 1'b0;
            end
        end else begin
            r_state <= n_state;
            r_done  <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_cmd <= i_cmd;
                        r_idx <= '0;
                        r_acc <= '0;
                        if (i_cmd.op == OP_CLEAR) begin
                            // new case: fresh root row, empty trie
                            r_clr_node   <= '0;
                            r_clr_cnt    <= '0;
                            r_clr_to_fin <= 1'b0;
                            r_nodes_used <= (NW+1)'(1);
                            r_ins_cur    <= '0;
                            r_ins_depth  <= '0;
                            r_ins_drop   <= 1'b0;
                            r_ovf        <= 1'b0;
                            r_prefix     <= WAYS_W'(1);
                            for (int s = 0; s < MAX_WORD_DIGITS; s++) begin
                                r_slot_alive[s] <= 1'b0;
                            end
                        end
                    end
                end
                ST_CLR: begin
                    r_clr_cnt <= r_clr_cnt + DW'(1);
                end
                ST_WRD: begin
                    r_addr <= row_addr(r_ins_cur, r_cmd.digit);
                    if (!r_ins_drop &&
                        (!dig_ok || r_ins_depth >= IW'(MAX_WORD_DIGITS))) begin
                        r_ins_drop <= 1'b1;
                    end
                end
                ST_WDAT: begin
                    if (child_q != '0) begin
                        r_ins_cur   <= child_q;
                        r_ins_depth <= r_ins_depth + IW'(1);
                    end else if (child_we) begin
                        // allocate the next node and sweep its row
                        r_ins_cur    <= r_nodes_used[NW-1:0];
                        r_ins_depth  <= r_ins_depth + IW'(1);
                        r_nodes_used <= r_nodes_used + (NW+1)'(1);
                        r_clr_node   <= r_nodes_used[NW-1:0];
                        r_clr_cnt    <= '0;
                        r_clr_to_fin <= 1'b1;
                    end else begin
                        r_ovf      <= 1'b1;
                        r_ins_drop <= 1'b1;
                    end
                end
                ST_WFIN: begin
                    if (r_cmd.last) begin
                        r_ins_cur   <= '0;
                        r_ins_depth <= '0;
                        r_ins_drop  <= 1'b0;
                    end
                end
                ST_MREQ: begin
                    if (!is_root && !(r_slot_alive[slot] && dig_ok)) begin
                        // idle slot, or a bad digit closes the cursor
                        r_slot_alive[slot] <= 1'b0;
                        r_idx              <= r_idx + IW'(1);
                    end
                end
                ST_MCHD: begin
                    if (child_q == '0) begin
                        if (!is_root) begin
                            r_slot_alive[slot] <= 1'b0;
                            r_idx              <= r_idx + IW'(1);
                        end
                    end else if (!is_root) begin
                        r_slot_node[slot] <= child_q;
                        r_add_ways        <= r_slot_ways[slot];
                    end else begin
                        r_add_ways <= r_prefix;
                        if (free_found) begin
                            r_slot_alive[free_slot] <= 1'b1;
                            r_slot_node[free_slot]  <= child_q;
                            r_slot_ways[free_slot]  <= r_prefix;
                        end
                    end
                end
                ST_MMRK: begin
                    if (mark_q) begin
                        r_acc <= acc_new;
                    end
                    if (!is_root) begin
                        r_idx <= r_idx + IW'(1);
                    end
                end
                ST_MEND: begin
                    // a zero digit carries the previous count over
                    if (!(dig_ok && r_cmd.digit == 4'd0)) begin
                        r_prefix <= r_acc;
                    end
                    if (r_cmd.last) begin
                        r_done         <= 1'b1;
                        r_res.ways     <= (dig_ok && r_cmd.digit == 4'd0) ? r_prefix : r_acc;
                        r_res.overflow <= r_ovf;
                        r_prefix       <= WAYS_W'(1);
                        for (int s = 0; s < MAX_WORD_DIGITS; s++) begin
                            r_slot_alive[s] <= 1'b0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

// ----- design/ddsc_checker.sv -----
`timescale 1ns / 1ps
module ddsc_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input ddsc_pkg::t_cmd    i_cmd,
    input logic              o_done,
    input ddsc_pkg::t_result o_result
);
    import ddsc_pkg::*;

    // count always reduced below the modulus
    a_ways_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ({1'b0, o_result.ways} < WAYS_MOD))
        else $error("ways not reduced");

    // a result is a single-cycle strobe
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    // result only appears once the digit is finished
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result while busy");

    // a message digit always takes work
    a_msg_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd.op == OP_MSG) |=> busy)
        else $error("message digit not taken");

endmodule

bind digit_dictionary_segmentation_count ddsc_checker u_ddsc_checker (.*);

// ----- test/tb_digit_dictionary_segmentation_count.sv -----
`timescale 1ns / 1ps
module tb_digit_dictionary_segmentation_count;
    import ddsc_pkg::*;

    localparam int NODES      = 1024;
    localparam int WORD_MAX   = 9;
    localparam int BASE       = 10;
    localparam int MODULUS    = 1000000007;
    localparam logic [1:0] OP_IGNORED = 2'd3;
    // settle margin covers the longest message digit and a node allocation sweep
    localparam int SETTLE_CYCLES = 48;
    localparam int RANDOM_ITEMS  = 550;

    logic    i_clk;
    logic    i_rst_n;
    logic    start;
    logic    busy;
    t_cmd    i_cmd;
    logic    o_done;
    t_result o_result;

    digit_dictionary_segmentation_count u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (i_cmd),
        .o_done   (o_done),
        .o_result (o_result)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // shadow copy of the trie, the cursors and the running count
    int   trie_child [NODES*BASE];
    bit   trie_mark  [NODES];
    int   trie_nodes;
    int   ins_node;
    int   ins_depth;
    bit   ins_dead;
    int   cur_node [WORD_MAX];
    bit   cur_live [WORD_MAX];
    int   cur_ways [WORD_MAX];
    int   run_ways;
    bit   ovf_flag;

    t_result pending_counts[$];
    int      errors;
    int      items_sent;
    int      counts_checked;
    int      overflow_counts;
    bit      sender_steady;

    function automatic int sum_mod(int a, int b);
        longint s;
        s = longint'(a) + longint'(b);
        return int'(s % MODULUS);
    endfunction

    task automatic end_message();
        for (int s = 0; s < WORD_MAX; s++) begin
            cur_node[s] = 0;
            cur_live[s] = 1'b0;
            cur_ways[s] = 0;
        end
        run_ways = 1;
    endtask

    task automatic clear_dictionary();
        for (int k = 0; k < NODES*BASE; k++) trie_child[k] = 0;
        for (int k = 0; k < NODES; k++) trie_mark[k] = 1'b0;
        trie_nodes = 1;
        ins_node   = 0;
        ins_depth  = 0;
        ins_dead   = 1'b0;
        ovf_flag   = 1'b0;
        end_message();
    endtask

    task automatic insert_digit(int d, bit fin);
        int nxt;
        if (!ins_dead) begin
            if (d >= BASE || ins_depth >= WORD_MAX) begin
                ins_dead = 1'b1;
            end else begin
                nxt = trie_child[ins_node*BASE + d];
                if (nxt == 0) begin
                    if (trie_nodes >= NODES) begin
                        ovf_flag = 1'b1;
                        ins_dead = 1'b1;
                    end else begin
                        nxt = trie_nodes;
                        trie_nodes++;
                        trie_child[ins_node*BASE + d] = nxt;
                    end
                end
                if (!ins_dead) begin
                    ins_node = nxt;
                    ins_depth++;
                end
            end
        end
        if (fin) begin
            if (!ins_dead) trie_mark[ins_node] = 1'b1;
            ins_node  = 0;
            ins_depth = 0;
            ins_dead  = 1'b0;
        end
    endtask

    task automatic advance_message(int d);
        bit ok;
        int acc;
        int nxt;
        ok  = (d < BASE);
        acc = 0;
        // step every live cursor along the new digit
        for (int s = 0; s < WORD_MAX; s++) begin
            if (cur_live[s]) begin
                nxt = ok ? trie_child[cur_node[s]*BASE + d] : 0;
                if (nxt == 0) begin
                    cur_live[s] = 1'b0;
                end else begin
                    cur_node[s] = nxt;
                    if (trie_mark[nxt]) acc = sum_mod(acc, cur_ways[s]);
                end
            end
        end
        // a nonzero digit may open a new word at this position
        if (ok && d != 0) begin
            nxt = trie_child[d];
            if (nxt != 0) begin
                for (int s = 0; s < WORD_MAX; s++) begin
                    if (!cur_live[s]) begin
                        cur_live[s] = 1'b1;
                        cur_node[s] = nxt;
                        cur_ways[s] = run_ways;
                        break;
                    end
                end
                if (trie_mark[nxt]) acc = sum_mod(acc, run_ways);
            end
        end
        // a zero digit carries the previous count over unchanged
        if (!(ok && d == 0)) run_ways = acc;
    endtask

    // step the shadow model; returns 1 with the count when a result is due
    task automatic predict_count(input t_cmd c, output bit due, output t_result r);
        due = 1'b0;
        r   = '0;
        case (c.op)
            OP_CLEAR: clear_dictionary();
            OP_WORD:  insert_digit(int'(c.digit), c.last);
            OP_MSG: begin
                advance_message(int'(c.digit));
                if (c.last) begin
                    due        = 1'b1;
                    r.ways     = run_ways[WAYS_W-1:0];
                    r.overflow = ovf_flag;
                    end_message();
                end
            end
            default: ;
        endcase
    endtask

    // one command transfer; a typed expectation overrides the shadow model
    task automatic send_cmd(t_cmd c, bit typed, t_result typed_val);
        int      gap;
        bit      due;
        t_result r;
        gap = sender_steady ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start = 1'b1;
        i_cmd = c;
        do @(posedge i_clk); while (busy);
        predict_count(c, due, r);
        if (due) begin
            if (typed) pending_counts.push_back(typed_val);
            else pending_counts.push_back(r);
        end
        items_sent++;
        @(negedge i_clk);
        start = 1'b0;
    endtask

    task automatic send(logic [1:0] op, int d, bit fin);
        t_cmd c;
        c.op    = op;
        c.digit = d[3:0];
        c.last  = fin;
        send_cmd(c, 1'b0, '0);
    endtask

    // hold off until every count is back, then let the block settle
    task automatic drain();
        start = 1'b0;
        while (pending_counts.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_done) begin
            if (pending_counts.size() == 0) begin
                $display("%0t: unexpected count ways=%0d overflow=%0b", $realtime,
                         o_result.ways, o_result.overflow);
                errors++;
            end else begin
                want = pending_counts.pop_front();
                counts_checked++;
                if (want.overflow) overflow_counts++;
                if (o_result.ways !== want.ways) begin
                    $display("%0t: ways expected %0d actual %0d", $realtime,
                             want.ways, o_result.ways);
                    errors++;
                end
                if (o_result.overflow !== want.overflow) begin
                    $display("%0t: overflow expected %0b actual %0b", $realtime,
                             want.overflow, o_result.overflow);
                    errors++;
                end
            end
        end
    end

    typedef struct {
        logic [1:0] op;
        int         digit;
        bit         fin;
        bit         typed;
        int         ways;
        bit         ovf;
    } t_row;

    t_row directed[$];

    function automatic t_row row(logic [1:0] op, int d, bit fin, bit typed = 0,
                                 int w = 0, bit o = 0);
        t_row x;
        x.op = op; x.digit = d; x.fin = fin; x.typed = typed; x.ways = w; x.ovf = o;
        return x;
    endfunction

    initial begin
        #20_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        int   words [16][WORD_MAX];
        int   wlen  [16];
        int   nwords;
        int   nmsg;
        int   target;
        int   mlen;
        int   digs [$];
        int   case_no;
        int   w;
        t_cmd c;
        t_result tv;

        errors = 0; items_sent = 0; counts_checked = 0; overflow_counts = 0;
        sender_steady = 1'b0;
        start   = 1'b0;
        i_cmd   = '0;
        i_rst_n = 1'b0;
        clear_dictionary();
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty dictionary, ignored op, bad digits, short words
        directed.push_back(row(OP_MSG,   1, 1, 1, 0, 0));
        directed.push_back(row(OP_MSG,   0, 1, 1, 1, 0));
        directed.push_back(row(OP_IGNORED, 15, 1));
        directed.push_back(row(OP_MSG,  15, 1, 1, 0, 0));
        directed.push_back(row(OP_WORD,  1, 1));
        directed.push_back(row(OP_WORD,  2, 1));
        directed.push_back(row(OP_WORD,  1, 0));
        directed.push_back(row(OP_WORD,  2, 1));
        directed.push_back(row(OP_WORD,  0, 1));
        directed.push_back(row(OP_WORD,  9, 0));
        directed.push_back(row(OP_WORD, 12, 1));
        directed.push_back(row(OP_WORD,  9, 1));
        directed.push_back(row(OP_MSG,   1, 0));
        directed.push_back(row(OP_MSG,   2, 1));
        directed.push_back(row(OP_MSG,   1, 0));
        directed.push_back(row(OP_MSG,   0, 0));
        directed.push_back(row(OP_MSG,   2, 1));
        directed.push_back(row(OP_MSG,   9, 0));
        directed.push_back(row(OP_MSG,  11, 0));
        directed.push_back(row(OP_MSG,   9, 1));
        directed.push_back(row(OP_CLEAR, 0, 0));
        directed.push_back(row(OP_MSG,   9, 1, 1, 0, 0));
        foreach (directed[i]) begin
            c.op = directed[i].op; c.digit = directed[i].digit[3:0]; c.last = directed[i].fin;
            tv.ways = directed[i].ways[WAYS_W-1:0]; tv.overflow = directed[i].ovf;
            send_cmd(c, directed[i].typed, tv);
        end
        drain();

        // random cases: a small dictionary, then messages built mostly from it
        case_no = 0;
        while (items_sent < RANDOM_ITEMS || case_no < 8) begin
            sender_steady = ($urandom_range(0, 3) == 0);
            send(OP_CLEAR, $urandom_range(0, 15), $urandom_range(0, 1));
            nwords = $urandom_range(1, 12);
            for (int j = 0; j < nwords; j++) begin
                wlen[j] = $urandom_range(1, 4);
                for (int k = 0; k < wlen[j]; k++) begin
                    words[j][k] = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 4);
                    if (case_no == 4 && k == 0) words[j][k] = $urandom_range(1, 9);
                    send(OP_WORD, words[j][k], k == wlen[j]-1);
                end
            end
            // noise: out-of-range digit, overlong word, ignored op
            if ($urandom_range(0, 2) == 0) send(OP_WORD, $urandom_range(10, 15), 1);
            if ($urandom_range(0, 3) == 0) begin
                for (int k = 0; k < WORD_MAX+1; k++)
                    send(OP_WORD, $urandom_range(1, 4), k == WORD_MAX);
            end
            if ($urandom_range(0, 3) == 0) send(OP_IGNORED, $urandom_range(0, 15), 1);
            nmsg = $urandom_range(1, 4);
            for (int m = 0; m < nmsg; m++) begin
                target = $urandom_range(1, 14);
                digs.delete();
                while (digs.size() < target) begin
                    if ($urandom_range(0, 3) != 0) begin
                        w = $urandom_range(0, nwords-1);
                        for (int k = 0; k < wlen[w]; k++) digs.push_back(words[w][k]);
                    end else if ($urandom_range(0, 7) == 0) begin
                        digs.push_back($urandom_range(10, 15));
                    end else begin
                        digs.push_back($urandom_range(0, 9));
                    end
                end
                mlen = digs.size();
                for (int k = 0; k < mlen; k++) send(OP_MSG, digs[k], k == mlen-1);
            end
            if (case_no % 3 == 2) drain();
            case_no++;
        end

        drain();
        $display("covered %0d command transfers over %0d random cases", items_sent, case_no);
        $display("checked %0d counts, %0d of them with trie overflow", counts_checked,
                 overflow_counts);
        if (errors == 0 && pending_counts.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
design/ddsc_pkg.sv
design/ddsc_trie_mem.sv
design/digit_dictionary_segmentation_count.sv
design/ddsc_checker.sv
test/tb_digit_dictionary_segmentation_count.sv
